>>> rtl/wams_pkg.sv
package wams_pkg;

    // matrix geometry
    localparam int MAX_VERTS   = 64;
    localparam int WEIGHT_BITS = 16;
    localparam int VIDX_W      = $clog2(MAX_VERTS);
    localparam int VCNT_W      = VIDX_W + 1;
    localparam int ECNT_W      = 16;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 16;

    // operation codes
    typedef enum logic [2:0] {
        FN_CLEAR  = 3'd0,
        FN_ADD    = 3'd1,
        FN_REMOVE = 3'd2,
        FN_LOOKUP = 3'd3,
        FN_NEXT   = 3'd4,
        FN_EMPTY  = 3'd5
    } func_t;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_INVALID   = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EMPTY_WEIGHT = 8'd1;

    typedef logic [MAX_VERTS-1:0][WEIGHT_BITS-1:0] row_t;

    typedef struct packed {
        logic [2:0]             func;
        logic [VIDX_W-1:0]      vertex_a;
        logic [VCNT_W-1:0]      vertex_b;
        logic [WEIGHT_BITS-1:0] weight;
    } item_t;

    typedef struct packed {
        logic [1:0]             status;
        logic                   present;
        logic [WEIGHT_BITS-1:0] weight_out;
        logic [VIDX_W-1:0]      next_vertex;
        logic [ECNT_W-1:0]      edge_count;
    } res_t;

    typedef struct packed {
        logic              we;
        logic [VIDX_W-1:0] waddr;
        row_t              wdata;
        logic              re;
        logic [VIDX_W-1:0] raddr;
    } ram_req_t;

    typedef struct packed {
        logic              load;
        logic [VCNT_W-1:0] lo;
        logic [VCNT_W-1:0] hi;
    } scan_req_t;

    typedef struct packed {
        logic              found;
        logic [VIDX_W-1:0] idx;
    } scan_res_t;

endpackage

>>> rtl/weighted_adjacency_matrix_store.sv
// Undirected weighted adjacency matrix of up to 64 vertices.
// Input beats on s_*: s_tuser carries the operation (clear, add, remove, lookup,
// next neighbor, row empty), s_tdata the vertices and the weight. Every input beat
// gives exactly one result beat on m_*, in order.
// Configuration writes on cfg_* (vertex_count, empty_weight) are taken every cycle
// and are meant for idle periods only.
// One item is in flight at a time. The matrix lives in a 64-row memory, one full row
// per word, with a registered read. Clear, spare codes and invalid vertices touch no
// row; lookup and a remove that misses read one row; next neighbor and row empty read
// one row and scan it (bitmap register, then priority encoder); add and remove
// read-modify-write both symmetric rows in turn. The next input beat can be taken in
// the cycle after the result is loaded into the output register.
// Reset empties the matrix at once through per-row valid bits (no clearing pass),
// zeroes the edge count and sets vertex_count to 64 and empty_weight to 0.
// A stalled result stays in the output register; a further finished result waits
// in the sequencer until the register frees, and no input is taken meanwhile.
module weighted_adjacency_matrix_store
    import wams_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // vertex_a[5:0], vertex_b[12:6], weight[28:13], zero fill
    input  logic [31:0]           s_tdata,
    // func[2:0]
    input  logic [2:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // present[0], weight_out[16:1], next_vertex[22:17], edge_count[38:23], zero fill
    output logic [39:0]           m_tdata,
    // status[1:0]
    output logic [1:0]            m_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [VCNT_W-1:0]      vcount_reg;
    logic [WEIGHT_BITS-1:0] empty_reg;
    logic                   m_tvalid_reg;
    res_t                   out_reg;

    item_t     in_item;
    ram_req_t  ram_req;
    row_t      ram_rdata, row_eff;
    scan_req_t scan_req;
    scan_res_t scan_res;
    logic      res_valid, res_ready;
    res_t      res;

    // configuration registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg <= VCNT_W'(MAX_VERTS);
            empty_reg  <= '0;
        end else if (cfg_valid) begin
            if (cfg_index == REG_VERTEX_COUNT) begin
                vcount_reg <= cfg_data[VCNT_W-1:0];
            end else if (cfg_index == REG_EMPTY_WEIGHT) begin
                empty_reg <= cfg_data[WEIGHT_BITS-1:0];
            end
        end
    end

    // input unpack
    assign in_item.func     = s_tuser;
    assign in_item.vertex_a = s_tdata[5:0];
    assign in_item.vertex_b = s_tdata[12:6];
    assign in_item.weight   = s_tdata[28:13];

    wams_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .vcount    (vcount_reg),
        .empty_w   (empty_reg),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .scan_req  (scan_req),
        .row_eff   (row_eff),
        .scan_res  (scan_res),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    wams_row_ram u_ram (
        .aclk  (aclk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    wams_row_scan u_scan (
        .aclk (aclk),
        .req  (scan_req),
        .row  (row_eff),
        .ev   (empty_reg),
        .res  (scan_res)
    );

    // output register
    assign res_ready = !m_tvalid_reg || m_tready;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end
    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {1'b0, out_reg.edge_count, out_reg.next_vertex,
                       out_reg.weight_out, out_reg.present};

endmodule

>>> rtl/wams_row_ram.sv
module wams_row_ram
    import wams_pkg::*;
(
    input  logic     aclk,
    input  ram_req_t req,
    output row_t     rdata
);

    row_t mem [MAX_VERTS];
    row_t rdata_reg;

    // one row write and one registered row read per cycle
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re) begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/wams_row_scan.sv
module wams_row_scan
    import wams_pkg::*;
(
    input  logic                   aclk,
    input  scan_req_t              req,
    input  row_t                   row,
    input  logic [WEIGHT_BITS-1:0] ev,
    output scan_res_t              res
);

    logic [MAX_VERTS-1:0] hit_reg;
    logic [MAX_VERTS-1:0] hit_next;
    logic [VIDX_W-1:0]    idx;

    // presence bitmap, limited to the cursor window
    always_comb begin
        for (int i = 0; i < MAX_VERTS; i++) begin
            hit_next[i] = (row[i] != ev) && (VCNT_W'(i) >= req.lo) && (VCNT_W'(i) < req.hi);
        end
    end

    always_ff @(posedge aclk) begin
        if (req.load) begin
            hit_reg <= hit_next;
        end
    end

    // lowest set bit wins
    always_comb begin
        idx = '0;
        for (int i = MAX_VERTS - 1; i >= 0; i--) begin
            if (hit_reg[i]) begin
                idx = VIDX_W'(i);
            end
        end
    end

    assign res.found = |hit_reg;
    assign res.idx   = idx;

endmodule

>>> rtl/wams_ctrl.sv
module wams_ctrl
    import wams_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  item_t                  in_item,
    input  logic [VCNT_W-1:0]      vcount,
    input  logic [WEIGHT_BITS-1:0] empty_w,
    output ram_req_t               ram_req,
    input  row_t                   ram_rdata,
    output scan_req_t              scan_req,
    output row_t                   row_eff,
    input  scan_res_t              scan_res,
    output logic                   res_valid,
    input  logic                   res_ready,
    output res_t                   res
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DEC  = 7'b0000010,
        S_EVA  = 7'b0000100,
        S_RDB  = 7'b0001000,
        S_EVB  = 7'b0010000,
        S_SCAN = 7'b0100000,
        S_DONE = 7'b1000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [MAX_VERTS-1:0]   valid_reg, valid_next;
    logic [WEIGHT_BITS-1:0] fill_reg, fill_next;
    logic [ECNT_W-1:0]      cnt_reg, cnt_next;
    item_t                  item_reg, item_next;
    res_t                   res_reg, res_next;
    logic [VIDX_W-1:0]      rd_row_reg, rd_row_next;

    logic [VCNT_W-1:0]      n;
    logic                   a_ok, b_ok;
    logic [WEIGHT_BITS-1:0] ev, w, entry;
    logic [VIDX_W-1:0]      b_idx;
    row_t                   fill_row, wrow;

    assign ev    = empty_w;
    assign w     = item_reg.weight;
    assign b_idx = item_reg.vertex_b[VIDX_W-1:0];
    assign n     = (vcount > VCNT_W'(MAX_VERTS)) ? VCNT_W'(MAX_VERTS) : vcount;
    assign a_ok  = {1'b0, item_reg.vertex_a} < n;
    assign b_ok  = !item_reg.vertex_b[VCNT_W-1] && (item_reg.vertex_b < n);

    // rows never written since the last clear or reset read as the fill value
    always_comb begin
        for (int i = 0; i < MAX_VERTS; i++) begin
            fill_row[i] = fill_reg;
        end
    end
    assign row_eff = valid_reg[rd_row_reg] ? ram_rdata : fill_row;

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    always_comb begin
        res            = res_reg;
        res.edge_count = cnt_reg;
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        valid_next   = valid_reg;
        fill_next    = fill_reg;
        cnt_next     = cnt_reg;
        item_next    = item_reg;
        res_next     = res_reg;
        rd_row_next  = rd_row_reg;
        ram_req      = '0;
        ram_req.wdata = row_eff;
        scan_req.load = 1'b0;
        scan_req.hi   = n;
        scan_req.lo   = '0;
        entry         = '0;
        wrow          = row_eff;
        if ((item_reg.func == FN_NEXT) && !item_reg.vertex_b[VCNT_W-1]) begin
            scan_req.lo = item_reg.vertex_b + VCNT_W'(1);
        end

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    item_next  = in_item;
                    res_next   = '0;
                    res_next.weight_out = ev;
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                state_next = S_DONE;
                unique case (item_reg.func)
                    FN_CLEAR: begin
                        valid_next = '0;
                        fill_next  = ev;
                        cnt_next   = '0;
                    end
                    FN_ADD, FN_REMOVE, FN_LOOKUP: begin
                        if (!a_ok || !b_ok) begin
                            res_next.status = ST_INVALID;
                        end else begin
                            ram_req.re  = 1'b1;
                            ram_req.raddr = item_reg.vertex_a;
                            rd_row_next = item_reg.vertex_a;
                            state_next  = S_EVA;
                        end
                    end
                    FN_NEXT, FN_EMPTY: begin
                        if (item_reg.func == FN_EMPTY) begin
                            res_next.present = 1'b1;
                        end
                        if (!a_ok) begin
                            res_next.status = ST_INVALID;
                        end else begin
                            ram_req.re  = 1'b1;
                            ram_req.raddr = item_reg.vertex_a;
                            rd_row_next = item_reg.vertex_a;
                            state_next  = S_EVA;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_EVA: begin
                entry = row_eff[b_idx];
                unique case (item_reg.func)
                    FN_ADD: begin
                        wrow[b_idx]   = w;
                        ram_req.we    = 1'b1;
                        ram_req.waddr = item_reg.vertex_a;
                        ram_req.wdata = wrow;
                        valid_next[item_reg.vertex_a] = 1'b1;
                        state_next    = S_RDB;
                    end
                    FN_REMOVE: begin
                        if (entry == ev) begin
                            res_next.status = ST_NOT_FOUND;
                            state_next      = S_DONE;
                        end else begin
                            res_next.present    = 1'b1;
                            res_next.weight_out = entry;
                            wrow[b_idx]   = ev;
                            ram_req.we    = 1'b1;
                            ram_req.waddr = item_reg.vertex_a;
                            ram_req.wdata = wrow;
                            valid_next[item_reg.vertex_a] = 1'b1;
                            state_next    = S_RDB;
                        end
                    end
                    FN_LOOKUP: begin
                        if (entry == ev) begin
                            res_next.status = ST_NOT_FOUND;
                        end else begin
                            res_next.present    = 1'b1;
                            res_next.weight_out = entry;
                        end
                        state_next = S_DONE;
                    end
                    default: begin
                        scan_req.load = 1'b1;
                        state_next    = S_SCAN;
                    end
                endcase
            end
            S_RDB: begin
                ram_req.re    = 1'b1;
                ram_req.raddr = b_idx;
                rd_row_next   = b_idx;
                state_next    = S_EVB;
            end
            S_EVB: begin
                wrow[item_reg.vertex_a] = (item_reg.func == FN_ADD) ? w : ev;
                ram_req.we    = 1'b1;
                ram_req.waddr = b_idx;
                ram_req.wdata = wrow;
                valid_next[b_idx] = 1'b1;
                if (item_reg.func == FN_ADD) begin
                    res_next.present = (w != ev);
                    if (cnt_reg != '1) begin
                        cnt_next = cnt_reg + ECNT_W'(1);
                    end
                end else if (cnt_reg != '0) begin
                    cnt_next = cnt_reg - ECNT_W'(1);
                end
                state_next = S_DONE;
            end
            S_SCAN: begin
                if (item_reg.func == FN_NEXT) begin
                    if (scan_res.found) begin
                        res_next.next_vertex = scan_res.idx;
                    end else begin
                        res_next.status = ST_NOT_FOUND;
                    end
                end else begin
                    res_next.present = !scan_res.found;
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            fill_reg  <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            fill_reg  <= fill_next;
            cnt_reg   <= cnt_next;
        end
    end

    // item and result payload
    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        res_reg    <= res_next;
        rd_row_reg <= rd_row_next;
    end

endmodule

>>> rtl/wams_checker.sv
module wams_checker
    import wams_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [39:0]           m_tdata,
    input logic [1:0]            m_tuser
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // one item in flight: no input right after an accepted beat
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in flight");

    // status stays within its codes
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ST_OK) || (m_tuser == ST_INVALID) || (m_tuser == ST_NOT_FOUND))
        else $error("undefined status code");

    // a miss reports no edge and no neighbor
    a_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_NOT_FOUND) |-> !m_tdata[0] && (m_tdata[22:17] == '0))
        else $error("not-found result carries an edge or neighbor");

endmodule

bind weighted_adjacency_matrix_store wams_checker u_wams_checker (.*);
